// ===== hw/rtl/tvp_pkg.sv =====
// Shared constants for the trapezoidal velocity profile block.
// No dependencies; imported by trapezoidal_velocity_profile.
package tvp_pkg;

  // Width of a distance in millimetres (travelled and move_length).
  localparam int DIST_W = 20;

  // Field widths of a result word.
  localparam int SPEED_W = 16;
  localparam int PHASE_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (DIST_W > SPEED_W) ? DIST_W : SPEED_W;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 2'd2;

  // Profile phase codes.
  localparam logic [PHASE_W-1:0] PH_ACCEL  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CRUISE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DECEL  = 2'd2;

  // Stream data widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((DIST_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SPEED_W + PHASE_W + 7) / 8) * 8;

endpackage

// ===== hw/rtl/trapezoidal_velocity_profile.sv =====
// Trapezoidal velocity profile: distance travelled in, allowed speed and phase out.
// Holds the configuration registers, the profile setup sequencer and the
// per-word pipeline with a stage-per-bit square root. Depends on tvp_pkg.
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid / tready         tdata: travelled
//  m_axis    out        tvalid / tready         tdata: speed, phase
//  cfg       in         cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// One word is accepted per cycle while the setup sequencer is idle and m_axis does not stall;
// its result passes the a and b stages, the one-bit-per-stage square root pipeline and the output register.
// After reset and after every configuration write the setup sequencer runs
// (through a square root state too for a triangular profile, whose peak needs a
// square root of its own), during which s_axis_tready is low. A stall on m_axis
// freezes the whole pipeline at once, so no word is dropped or repeated.
module trapezoidal_velocity_profile (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tvp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // s_axis_tdata fields from bit 0: travelled
  input  logic [tvp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // m_axis_tdata fields from bit 0: speed, phase
  output logic [tvp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import tvp_pkg::*;

  // Derived widths.
  localparam int PROD_W   = DIST_W + 17;                   // 2a * distance
  localparam int RAD_RAW  = (PROD_W > 32) ? PROD_W : 32;
  localparam int RAD_W    = RAD_RAW + (RAD_RAW % 2);        // pipeline radicand
  localparam int SQ_N     = RAD_W / 2;                      // root bits / stages
  localparam int REM_W    = SQ_N + 2;
  localparam int MP_W     = DIST_W + 16;                    // a * move_length
  localparam int SR_W     = MP_W + (MP_W % 2);
  localparam int SR_N     = SR_W / 2;
  localparam int SREM_W   = SR_N + 2;
  localparam int DIV_N    = 32;
  localparam int CNT_W    = $clog2(DIV_N);

  // Setup sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]  len_q;
  logic [15:0]        vmax_q;
  logic [15:0]        acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      vmax_q <= 16'd1;
      acc_q  <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MOVE_LENGTH: len_q  <= cfg_data_i[DIST_W-1:0];
        REG_TOP_SPEED:   vmax_q <= cfg_data_i[15:0];
        REG_ACCEL_LIMIT: acc_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Setup sequencer: ramp length, deceleration start, peak and peak squared
  // ---------------------------------------------------------------------------
  logic [2:0]         st_q, st_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [16:0]        a2_q, a2_d;
  logic [31:0]        dvd_q, dvd_d;
  logic [16:0]        drem_q, drem_d;
  logic [31:0]        quo_q, quo_d;
  logic [MP_W-1:0]    mlp_q, mlp_d;
  logic [SR_W-1:0]    srad_q, srad_d;
  logic [SREM_W-1:0]  srem_q, srem_d;
  logic [SR_N-1:0]    sroot_q, sroot_d;
  logic [DIST_W-1:0]  ramp_q, ramp_d;
  logic [DIST_W-1:0]  dstart_q, dstart_d;
  logic [15:0]        peak_q, peak_d;
  logic [31:0]        psq_q, psq_d;

  logic [15:0]        a_eff;
  logic [17:0]        div_sh;
  logic               div_ge;
  logic [SREM_W+1:0]  s_r4;
  logic [SREM_W+1:0]  s_trial;
  logic               s_ge;
  logic [32:0]        twice_ramp;
  logic               tri_prof;
  logic [31:0]        sroot_ext;

  assign a_eff      = (acc_q == 16'd0) ? 16'd1 : acc_q;
  assign div_sh     = {drem_q, dvd_q[31]};
  assign div_ge     = div_sh >= {1'b0, a2_q};
  assign s_r4       = {srem_q, srad_q[SR_W-1 -: 2]};
  assign s_trial    = (SREM_W + 2)'({sroot_q, 2'b01});
  assign s_ge       = s_r4 >= s_trial;
  assign twice_ramp = {quo_q, 1'b0};
  assign tri_prof   = 33'(len_q) <= twice_ramp;

  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    a2_d     = a2_q;
    dvd_d    = dvd_q;
    drem_d   = drem_q;
    quo_d    = quo_q;
    mlp_d    = mlp_q;
    srad_d   = srad_q;
    srem_d   = srem_q;
    sroot_d  = sroot_q;
    ramp_d   = ramp_q;
    dstart_d = dstart_q;
    peak_d   = peak_q;
    psq_d    = psq_q;
    sroot_ext = '0;

    unique case (st_q)
      ST_IDLE: ;
      ST_PREP: begin
        a2_d   = {a_eff, 1'b0};
        dvd_d  = 32'(vmax_q) * 32'(vmax_q);
        mlp_d  = MP_W'(a_eff) * MP_W'(len_q);
        drem_d = '0;
        quo_d  = '0;
        cnt_d  = CNT_W'(DIV_N - 1);
        st_d   = ST_DIV;
      end
      ST_DIV: begin
        // Restoring division of top_speed^2 by 2a, one quotient bit a cycle.
        drem_d = div_ge ? 17'(div_sh - {1'b0, a2_q}) : div_sh[16:0];
        quo_d  = {quo_q[30:0], div_ge};
        dvd_d  = {dvd_q[30:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (tri_prof) begin
          ramp_d   = len_q >> 1;
          dstart_d = len_q >> 1;
          srad_d   = SR_W'(mlp_q);
          srem_d   = '0;
          sroot_d  = '0;
          cnt_d    = CNT_W'(SR_N - 1);
          st_d     = ST_SQRT;
        end else begin
          // Without a triangle the ramp is below half the move length.
          ramp_d   = quo_q[DIST_W-1:0];
          dstart_d = len_q - quo_q[DIST_W-1:0];
          peak_d   = vmax_q;
          st_d     = ST_FIN;
        end
      end
      ST_SQRT: begin
        srem_d  = s_ge ? SREM_W'(s_r4 - s_trial) : SREM_W'(s_r4);
        sroot_d = {sroot_q[SR_N-2:0], s_ge};
        srad_d  = srad_q << 2;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          sroot_ext = 32'(sroot_d);
          peak_d    = (sroot_ext > 32'hFFFF) ? 16'hFFFF : sroot_ext[15:0];
          st_d      = ST_FIN;
        end
      end
      ST_FIN: begin
        psq_d = 32'(peak_q) * 32'(peak_q);
        st_d  = ST_IDLE;
      end
      default: st_d = ST_PREP;
    endcase

    // Any write restarts the setup with the new register values.
    if (cfg_we_i) begin
      st_d = ST_PREP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_PREP;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a2_q     <= a2_d;
    dvd_q    <= dvd_d;
    drem_q   <= drem_d;
    quo_q    <= quo_d;
    mlp_q    <= mlp_d;
    srad_q   <= srad_d;
    srem_q   <= srem_d;
    sroot_q  <= sroot_d;
    ramp_q   <= ramp_d;
    dstart_q <= dstart_d;
    peak_q   <= peak_d;
    psq_q    <= psq_d;
  end

  // ---------------------------------------------------------------------------
  // Word pipeline
  // ---------------------------------------------------------------------------
  logic               adv;
  logic               in_acc;
  logic [DIST_W-1:0]  in_d;
  logic [PHASE_W-1:0] in_ph;
  logic [DIST_W-1:0]  in_op;

  logic               a_vld_q;
  logic [PHASE_W-1:0] a_ph_q;
  logic [DIST_W-1:0]  a_op_q;
  logic               b_vld_q;
  logic [PHASE_W-1:0] b_ph_q;
  logic [PROD_W-1:0]  b_prod_q;
  logic [RAD_W-1:0]   c_rad;

  logic               sq_vld_q  [SQ_N+1];
  logic [PHASE_W-1:0] sq_ph_q   [SQ_N+1];
  logic [RAD_W-1:0]   sq_rad_q  [SQ_N+1];
  logic [REM_W-1:0]   sq_rem_q  [SQ_N+1];
  logic [SQ_N-1:0]    sq_root_q [SQ_N+1];
  logic [RAD_W-1:0]   sq_rad_d  [SQ_N+1];
  logic [REM_W-1:0]   sq_rem_d  [SQ_N+1];
  logic [SQ_N-1:0]    sq_root_d [SQ_N+1];
  logic [REM_W+1:0]   sq_r4     [SQ_N+1];
  logic [REM_W+1:0]   sq_trial  [SQ_N+1];
  logic               sq_ge     [SQ_N+1];

  logic               o_vld_q;
  logic [15:0]        o_speed_q, o_speed_d;
  logic [PHASE_W-1:0] o_ph_q;
  logic [31:0]        root_ext;

  // The whole pipeline moves together whenever the output register can take a word.
  assign adv           = !o_vld_q || m_axis_tready;
  assign s_axis_tready = adv && (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_d          = s_axis_tdata[DIST_W-1:0];

  always_comb begin
    if (in_d < ramp_q) begin
      in_ph = PH_ACCEL;
      in_op = in_d;
    end else if (in_d < dstart_q) begin
      in_ph = PH_CRUISE;
      in_op = '0;
    end else begin
      in_ph = PH_DECEL;
      in_op = in_d - dstart_q;
    end
  end

  // Cruise takes the root of peak^2, which is the peak itself.
  always_comb begin
    case (b_ph_q)
      PH_ACCEL:  c_rad = RAD_W'(b_prod_q);
      PH_CRUISE: c_rad = RAD_W'(psq_q);
      default: begin
        if (RAD_W'(b_prod_q) >= RAD_W'(psq_q)) begin
          c_rad = '0;
        end else begin
          c_rad = RAD_W'(psq_q) - RAD_W'(b_prod_q);
        end
      end
    endcase
  end

  // One root bit per stage.
  always_comb begin
    for (int k = 0; k <= SQ_N; k++) begin
      sq_r4[k]     = '0;
      sq_trial[k]  = '0;
      sq_ge[k]     = 1'b0;
      sq_rad_d[k]  = '0;
      sq_rem_d[k]  = '0;
      sq_root_d[k] = '0;
    end
    sq_rad_d[0] = c_rad;
    for (int k = 1; k <= SQ_N; k++) begin
      sq_r4[k]     = {sq_rem_q[k-1], sq_rad_q[k-1][RAD_W-1 -: 2]};
      sq_trial[k]  = (REM_W + 2)'({sq_root_q[k-1], 2'b01});
      sq_ge[k]     = sq_r4[k] >= sq_trial[k];
      sq_rem_d[k]  = sq_ge[k] ? REM_W'(sq_r4[k] - sq_trial[k]) : REM_W'(sq_r4[k]);
      sq_root_d[k] = {sq_root_q[k-1][SQ_N-2:0], sq_ge[k]};
      sq_rad_d[k]  = sq_rad_q[k-1] << 2;
    end
  end

  assign root_ext  = 32'(sq_root_q[SQ_N]);
  assign o_speed_d = (root_ext > 32'hFFFF) ? 16'hFFFF : root_ext[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
      for (int k = 0; k <= SQ_N; k++) begin
        sq_vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      a_vld_q     <= in_acc;
      b_vld_q     <= a_vld_q;
      sq_vld_q[0] <= b_vld_q;
      for (int k = 1; k <= SQ_N; k++) begin
        sq_vld_q[k] <= sq_vld_q[k-1];
      end
      o_vld_q <= sq_vld_q[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_ph_q   <= in_ph;
      a_op_q   <= in_op;
      b_ph_q   <= a_ph_q;
      b_prod_q <= PROD_W'(a2_q) * PROD_W'(a_op_q);
      sq_ph_q[0]   <= b_ph_q;
      for (int k = 0; k <= SQ_N; k++) begin
        sq_rad_q[k]  <= sq_rad_d[k];
        sq_rem_q[k]  <= sq_rem_d[k];
        sq_root_q[k] <= sq_root_d[k];
      end
      for (int k = 1; k <= SQ_N; k++) begin
        sq_ph_q[k] <= sq_ph_q[k-1];
      end
      o_speed_q <= o_speed_d;
      o_ph_q    <= sq_ph_q[SQ_N];
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({o_ph_q, o_speed_q});

endmodule

// ===== tb/sv/trapezoidal_velocity_profile_test.sv =====
// Self-checking testbench for trapezoidal_velocity_profile: predicts speed and phase
// for every accepted distance word and checks each result word in order.
// Depends on tvp_pkg and the trapezoidal_velocity_profile RTL.
module trapezoidal_velocity_profile_test;
  import tvp_pkg::*;

  localparam int unsigned DIST_MAX    = (1 << DIST_W) - 1;
  localparam int unsigned SPEED_MAX   = (1 << SPEED_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Settling time after the last result before touching the registers.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS   = 145;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [PHASE_W-1:0] phase;
  } profile_point_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // s_axis_tdata fields from bit 0: travelled
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // m_axis_tdata fields from bit 0: speed, phase
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;

  // Shadow copy of the configuration registers.
  longint unsigned cfg_len = 0;
  longint unsigned cfg_vmax = 1;
  longint unsigned cfg_accel = 1;

  logic [DIST_W-1:0] pending_travel[$];
  profile_point_t    expected_points[$];
  profile_point_t    want_point;
  int                mismatch_count = 0;
  int                cycle_count = 0;

  logic        send_steady = 1'b1;
  int          burst_left = 0;
  int          gap_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  ready_step = '0;

  trapezoidal_velocity_profile dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int i = 19; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  // Shape of the profile under the current registers. A zero acceleration counts as one.
  function automatic void plan_profile(output longint unsigned accel,
                                       output longint unsigned ramp,
                                       output longint unsigned decel_start,
                                       output longint unsigned peak);
    accel = (cfg_accel == 0) ? 1 : cfg_accel;
    ramp = (cfg_vmax * cfg_vmax) / (2 * accel);
    if (cfg_len <= 2 * ramp) begin
      // Too short to cruise: the profile folds into a triangle.
      ramp = cfg_len >> 1;
      peak = floor_root(accel * cfg_len);
      if (peak > 64'(SPEED_MAX)) peak = 64'(SPEED_MAX);
      decel_start = ramp;
    end else begin
      peak = cfg_vmax;
      decel_start = cfg_len - ramp;
    end
  endfunction

  function automatic profile_point_t predict_point(input logic [DIST_W-1:0] travelled);
    longint unsigned accel, ramp, decel_start, peak, d, root, sq, drop;
    profile_point_t pt;
    plan_profile(accel, ramp, decel_start, peak);
    d = 64'(travelled);
    if (d < ramp) begin
      root = floor_root(2 * accel * d);
      pt.phase = PH_ACCEL;
    end else if (d < decel_start) begin
      root = peak;
      pt.phase = PH_CRUISE;
    end else begin
      sq = peak * peak;
      drop = 2 * accel * (d - decel_start);
      root = (drop >= sq) ? 0 : floor_root(sq - drop);
      pt.phase = PH_DECEL;
    end
    pt.speed = (root > 64'(SPEED_MAX)) ? SPEED_MAX[SPEED_W-1:0] : root[SPEED_W-1:0];
    return pt;
  endfunction

  // Sender: bursts of random length separated by random gaps, unless steady.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0 && !send_steady) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_travel.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'(pending_travel.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a rotating 16-bit pattern chosen per phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_step <= '0;
    end else begin
      ready_step <= ready_step + 1'b1;
      m_axis_tready <= ready_pattern[ready_step];
    end
  end

  // Check results before recording new words: a word accepted now cannot
  // produce the result seen in the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_points.size() == 0) begin
          $error("result word with none expected: speed %0d phase %0d",
                 m_axis_tdata[SPEED_W-1:0], m_axis_tdata[SPEED_W+:PHASE_W]);
          mismatch_count++;
        end else begin
          want_point = expected_points.pop_front();
          if (m_axis_tdata[SPEED_W-1:0] !== want_point.speed) begin
            $error("speed: expected %0d, actual %0d",
                   want_point.speed, m_axis_tdata[SPEED_W-1:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[SPEED_W+:PHASE_W] !== want_point.phase) begin
            $error("phase: expected %0d, actual %0d",
                   want_point.phase, m_axis_tdata[SPEED_W+:PHASE_W]);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_points.push_back(predict_point(s_axis_tdata[DIST_W-1:0]));
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_MOVE_LENGTH: cfg_len = 64'(data[DIST_W-1:0]);
      REG_TOP_SPEED:   cfg_vmax = 64'(data[SPEED_W-1:0]);
      REG_ACCEL_LIMIT: cfg_accel = 64'(data[SPEED_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic load_profile(input longint unsigned len, input longint unsigned vmax,
                              input longint unsigned accel);
    // Top speed sometimes carries junk above bit 15, which the block drops.
    write_reg(REG_MOVE_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_TOP_SPEED, CFG_DATA_W'(vmax[SPEED_W-1:0])
                             | (CFG_DATA_W'($urandom_range(0, 15)) << SPEED_W));
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(REG_ACCEL_LIMIT, CFG_DATA_W'(accel[SPEED_W-1:0]));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (pending_travel.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int p);
    longint unsigned len, vmax, accel, a, ramp, decel_start, peak, d;
    case ($urandom_range(0, 4))
      0: begin
        len = 64'($urandom_range(0, DIST_MAX));
        vmax = 64'($urandom_range(0, SPEED_MAX));
        accel = 64'($urandom_range(0, SPEED_MAX));
      end
      1: begin
        // Top speed picked so that the ramps leave a cruise section.
        accel = 64'($urandom_range(1, SPEED_MAX));
        len = 64'($urandom_range(64, DIST_MAX));
        vmax = floor_root(accel * len / 64'($urandom_range(2, 8)));
        if (vmax > 64'(SPEED_MAX)) vmax = 64'(SPEED_MAX);
      end
      2: begin
        len = 64'($urandom_range(0, 4000));
        vmax = 64'($urandom_range(0, SPEED_MAX));
        accel = 64'($urandom_range(0, 200));
      end
      3: begin
        len = ($urandom_range(0, 1) == 0) ? 64'(DIST_MAX) : 64'($urandom_range(0, 1));
        vmax = ($urandom_range(0, 1) == 0) ? 64'(SPEED_MAX) : 64'($urandom_range(0, 1));
        accel = ($urandom_range(0, 1) == 0) ? 64'(SPEED_MAX) : 64'($urandom_range(0, 1));
      end
      default: begin
        len = 64'($urandom_range(0, 300));
        vmax = 64'($urandom_range(0, 40));
        accel = 64'($urandom_range(0, 20));
      end
    endcase
    if (p == 0) begin
      len = 64'(DIST_MAX);
      vmax = 64'(SPEED_MAX);
      accel = 64'(SPEED_MAX);
    end else if (p == 1) begin
      len = 64'(DIST_MAX);
      vmax = 64'(SPEED_MAX);
      accel = 1;
    end
    load_profile(len, vmax, accel);
    plan_profile(a, ramp, decel_start, peak);
    @(negedge clk_i);
    send_steady = ($urandom_range(0, 3) == 0);
    // Every pattern keeps at least one ready cycle so the results always drain.
    case ($urandom_range(0, 3))
      0: ready_pattern = 16'hFFFF;
      1: ready_pattern = 16'($urandom) | 16'h1;
      2: ready_pattern = 16'($urandom | $urandom) | 16'h1;
      default: ready_pattern = 16'($urandom & $urandom) | 16'h1;
    endcase
    for (int i = 0; i < PHASE_WORDS; i++) begin
      case ($urandom_range(0, 9))
        0: d = 64'($urandom_range(0, DIST_MAX));
        1: d = ramp + 64'($urandom_range(0, 4)) - 2;
        2: d = decel_start + 64'($urandom_range(0, 4)) - 2;
        3: d = cfg_len + 64'($urandom_range(0, 4)) - 2;
        default: d = 64'($urandom_range(0, 32'(cfg_len + cfg_len / 16 + 2)));
      endcase
      pending_travel.push_back(d[DIST_W-1:0]);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers as left by reset: a zero length move.
    @(negedge clk_i);
    pending_travel.push_back(20'd0);
    pending_travel.push_back(20'hFFFFF);
    drain();

    // Trapezoid: ramp 500 mm, deceleration from 1500 mm, end at 2000 mm.
    load_profile(2000, 100, 10);
    @(negedge clk_i);
    pending_travel.push_back(20'd0);
    pending_travel.push_back(20'd1);
    pending_travel.push_back(20'd499);
    pending_travel.push_back(20'd500);
    pending_travel.push_back(20'd1499);
    pending_travel.push_back(20'd1500);
    pending_travel.push_back(20'd1999);
    pending_travel.push_back(20'd2000);
    pending_travel.push_back(20'd2001);
    pending_travel.push_back(20'hFFFFF);
    pending_travel.push_back(20'hAAAAA);
    pending_travel.push_back(20'h55555);
    drain();

    // Too short to cruise: a triangle peaking at 300 mm.
    load_profile(601, 1000, 10);
    @(negedge clk_i);
    pending_travel.push_back(20'd0);
    pending_travel.push_back(20'd299);
    pending_travel.push_back(20'd300);
    pending_travel.push_back(20'd301);
    pending_travel.push_back(20'd600);
    pending_travel.push_back(20'd601);
    drain();

    // Zero top speed and zero acceleration.
    load_profile(500, 0, 0);
    @(negedge clk_i);
    pending_travel.push_back(20'd0);
    pending_travel.push_back(20'd250);
    pending_travel.push_back(20'd600);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tvp_pkg.sv
hw/rtl/trapezoidal_velocity_profile.sv
tb/sv/trapezoidal_velocity_profile_test.sv
